// ----- design/ifmt_pkg.sv -----
// Shared types, constants and character helpers for the integer to text formatter.
`default_nettype none

package ifmt_pkg;

   localparam int VALUE_W        = 32;
   localparam int RADIX_W        = 6;
   localparam int COUNT_W        = 6;
   localparam int CHAR_W         = 7;
   localparam int POS_W          = 8;
   localparam int DIGIT_W        = 6;
   localparam int PREFIX_W       = 2;

   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_WIDTH_DEF  = 60;

   localparam int RADIX_MIN      = 2;
   localparam int RADIX_MAX      = 36;
   localparam int RADIX_OCT      = 8;
   localparam int RADIX_HEX      = 16;
   localparam int DIGIT_TEN      = 10;
   localparam int PREFIX_LETTER  = 33;

   localparam int DIV_BITS       = 8;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CHAR_W-1:0] CH_NUL     = 7'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 7'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

   typedef enum logic [1:0] {
      SIGN_NONE,
      SIGN_MINUS,
      SIGN_PLUS,
      SIGN_SPACE
   } sign_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      logic [COUNT_W-1:0] text_width;
      logic [COUNT_W-1:0] min_digits;
      logic               zero_pad;
      logic               signed_value;
      logic               plus_sign;
      logic               space_sign;
      logic               left_justify;
      logic               alt_prefix;
      logic               lower_case;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last;
      logic              bad_base;
   } rsp_type;

   typedef struct packed {
      logic                bad;
      logic [VALUE_W-1:0]  mag;
      logic [RADIX_W-1:0]  radix;
      logic [POS_W-1:0]    width;
      logic [COUNT_W-1:0]  min_digits;
      logic                zpad;
      logic                left;
      logic                lower;
      logic [PREFIX_W-1:0] prefix_len;
      sign_type            sign;
   } job_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] digit,
                                                    input logic lower);
      logic [CHAR_W-1:0] base_char;
      base_char = lower ? CH_LOWER_A : CH_UPPER_A;
      if (digit < DIGIT_W'(DIGIT_TEN)) begin
         return CH_ZERO + CHAR_W'(digit);
      end else begin
         return base_char + CHAR_W'(digit - DIGIT_W'(DIGIT_TEN));
      end
   endfunction

   function automatic logic [CHAR_W-1:0] sign_char(input sign_type sign);
      logic [CHAR_W-1:0] ch;
      case (sign)
         SIGN_MINUS: ch = CH_MINUS;
         SIGN_PLUS:  ch = CH_PLUS;
         SIGN_SPACE: ch = CH_SPACE;
         default:    ch = CH_NUL;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- design/ifmt_front.sv -----
// Front end: accepts requests and classifies base, sign, magnitude and padding.
`default_nettype none

module ifmt_front #(
   parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
   parameter int MAX_WIDTH  = ifmt_pkg::MAX_WIDTH_DEF
) (
   input  wire              req_valid,
   output logic             req_ready,
   input  ifmt_pkg::req_type req_data,
   output logic             job_push,
   input  wire              job_ready,
   output ifmt_pkg::job_type job_data
);
   import ifmt_pkg::*;

   logic [VALUE_BITS-1:0] low_bits;
   logic                  negative;
   logic                  bad;
   logic                  left;
   logic [POS_W-1:0]      width_ext;

   always_comb begin
      low_bits  = req_data.value[VALUE_BITS-1:0];
      negative  = req_data.signed_value & low_bits[VALUE_BITS-1];
      bad       = (req_data.radix < RADIX_W'(RADIX_MIN)) ||
                  (req_data.radix > RADIX_W'(RADIX_MAX));
      left      = req_data.left_justify;
      width_ext = POS_W'(req_data.text_width);

      job_data.bad        = bad;
      job_data.mag        = VALUE_W'(negative ? (~low_bits + 1'b1) : low_bits);
      job_data.radix      = req_data.radix;
      job_data.width      = (width_ext > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : width_ext;
      job_data.min_digits = req_data.min_digits;
      job_data.zpad       = req_data.zero_pad & ~left;
      job_data.left       = left;
      job_data.lower      = req_data.lower_case;

      if (req_data.alt_prefix && (req_data.radix == RADIX_W'(RADIX_HEX))) begin
         job_data.prefix_len = PREFIX_W'(2);
      end else if (req_data.alt_prefix && (req_data.radix == RADIX_W'(RADIX_OCT))) begin
         job_data.prefix_len = PREFIX_W'(1);
      end else begin
         job_data.prefix_len = '0;
      end

      if (negative) begin
         job_data.sign = SIGN_MINUS;
      end else if (req_data.plus_sign) begin
         job_data.sign = SIGN_PLUS;
      end else if (req_data.space_sign) begin
         job_data.sign = SIGN_SPACE;
      end else begin
         job_data.sign = SIGN_NONE;
      end

      req_ready = job_ready;
      job_push  = req_valid & job_ready;
   end

endmodule

`default_nettype wire

// ----- design/ifmt_queue.sv -----
// Short queue of classified requests between the front end and the back end.
`default_nettype none

module ifmt_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              push_ready,
   input  ifmt_pkg::job_type push_data,
   output logic              pop_valid,
   input  wire               pop,
   output ifmt_pkg::job_type pop_data
);
   import ifmt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
      pop_valid  = (count_ff != '0);
      pop_data   = entry_ff[rd_ptr_ff];
      do_push    = push & push_ready;
      do_pop     = pop & pop_valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ifmt_back.sv -----
// Back end: digit conversion by iterative division, layout and character output.
`default_nettype none

module ifmt_back #(
   parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
   parameter int MAX_WIDTH  = ifmt_pkg::MAX_WIDTH_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               job_valid,
   output logic              job_pop,
   input  ifmt_pkg::job_type job_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output ifmt_pkg::rsp_type rsp_data
);
   import ifmt_pkg::*;

   localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_W     = DIV_STEPS * DIV_BITS;
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam int ND_W      = $clog2(VALUE_BITS + 1);
   localparam int DIG_IW    = $clog2(VALUE_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SETUP,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [ND_W-1:0]    nd_ff, nd_in;
   logic [POS_W-1:0]   b1_ff, b1_in;
   logic [POS_W-1:0]   b2_ff, b2_in;
   logic [POS_W-1:0]   b3_ff, b3_in;
   logic [POS_W-1:0]   b5_ff, b5_in;
   logic [POS_W-1:0]   b6_ff, b6_in;
   logic [POS_W-1:0]   lim_ff, lim_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [DIGIT_W-1:0] digit_ff [VALUE_BITS];
   logic               dig_we;

   logic [DIGIT_W:0]   part;
   logic [DIV_BITS-1:0] qbits;
   logic [DIV_W-1:0]   quo_next;
   logic [DIGIT_W-1:0] rem_next;

   logic [POS_W-1:0]   nd_ext;
   logic [POS_W-1:0]   prec;
   logic [POS_W-1:0]   sign_len;
   logic [POS_W-1:0]   size;
   logic [POS_W-1:0]   padn;
   logic [POS_W-1:0]   lead;
   logic [POS_W-1:0]   zfill;
   logic [POS_W-1:0]   trail;
   logic [POS_W-1:0]   b3_new;
   logic [POS_W-1:0]   b6_new;
   logic [POS_W-1:0]   total;

   logic [POS_W-1:0]   didx;
   logic [CHAR_W-1:0]  out_char;
   logic               out_last;
   logic               out_free;

   always_comb begin
      part  = {1'b0, rem_ff};
      qbits = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         part = {part[DIGIT_W-1:0], quo_ff[DIV_W-1-i]};
         if (part >= {1'b0, job_ff.radix}) begin
            part = part - {1'b0, job_ff.radix};
            qbits[DIV_BITS-1-i] = 1'b1;
         end
      end
      rem_next = part[DIGIT_W-1:0];
      quo_next = (quo_ff << DIV_BITS) | DIV_W'(qbits);
   end

   always_comb begin
      nd_ext   = POS_W'(nd_ff);
      prec     = (POS_W'(job_ff.min_digits) > nd_ext) ? POS_W'(job_ff.min_digits) : nd_ext;
      sign_len = POS_W'(job_ff.sign != SIGN_NONE);
      size     = job_ff.width - sign_len - POS_W'(job_ff.prefix_len) - prec;
      padn     = size[POS_W-1] ? '0 : size;
      lead     = (!job_ff.zpad && !job_ff.left) ? padn : '0;
      zfill    = job_ff.zpad ? padn : '0;
      trail    = job_ff.left ? padn : '0;
      b3_new   = lead + sign_len + POS_W'(job_ff.prefix_len);
      b6_new   = b3_new + zfill + prec;
      total    = b6_new + trail;
   end

   always_comb begin
      didx     = b6_ff - pos_ff - POS_W'(1);
      out_last = (pos_ff == lim_ff - POS_W'(1));
      if (job_ff.bad) begin
         out_char = CH_NUL;
      end else if (pos_ff < b1_ff) begin
         out_char = CH_SPACE;
      end else if (pos_ff < b2_ff) begin
         out_char = sign_char(job_ff.sign);
      end else if (pos_ff < b3_ff) begin
         out_char = (pos_ff == b2_ff) ? CH_ZERO :
                    digit_char(DIGIT_W'(PREFIX_LETTER), job_ff.lower);
      end else if (pos_ff < b5_ff) begin
         out_char = CH_ZERO;
      end else if (pos_ff < b6_ff) begin
         out_char = digit_char(digit_ff[didx[DIG_IW-1:0]], job_ff.lower);
      end else begin
         out_char = CH_SPACE;
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      nd_in        = nd_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b5_in        = b5_ff;
      b6_in        = b6_ff;
      lim_in       = lim_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      job_pop      = 1'b0;
      dig_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in  = job_data;
               quo_in  = DIV_W'(job_data.mag[VALUE_BITS-1:0]);
               rem_in  = '0;
               step_in = '0;
               nd_in   = '0;
               pos_in  = '0;
               if (job_data.bad) begin
                  lim_in   = POS_W'(1);
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            quo_in = quo_next;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               dig_we  = 1'b1;
               nd_in   = nd_ff + 1'b1;
               rem_in  = '0;
               step_in = '0;
               if ((quo_next == '0) || (nd_ff == ND_W'(VALUE_BITS - 1))) begin
                  state_in = ST_SETUP;
               end
            end else begin
               rem_in  = rem_next;
               step_in = step_ff + 1'b1;
            end
         end
         ST_SETUP: begin
            b1_in    = lead;
            b2_in    = lead + sign_len;
            b3_in    = b3_new;
            b5_in    = b3_new + zfill + (prec - nd_ext);
            b6_in    = b6_new;
            lim_in   = (total > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : total;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.text_char = out_char;
               rsp_in.last      = out_last;
               rsp_in.bad_base  = job_ff.bad;
               pos_in           = pos_ff + 1'b1;
               if (out_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (dig_we) begin
         digit_ff[nd_ff[DIG_IW-1:0]] <= rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         job_ff       <= job_in;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         step_ff      <= step_in;
         nd_ff        <= nd_in;
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         b3_ff        <= b3_in;
         b5_ff        <= b5_in;
         b6_ff        <= b6_in;
         lim_ff       <= lim_in;
         pos_ff       <= pos_in;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ----- design/integer_to_text_formatter_unit.sv -----
// Top level of the printf-style integer to text formatter.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  ifmt_pkg::req_type (value, radix, flags)
//   rsp      out        rsp_valid / rsp_ready  ifmt_pkg::rsp_type (text_char, last, bad_base)
//
// A request passes through the back end in order: division into digits, layout setup, then
// character output; the divider retires eight quotient bits a cycle.
// A bad base skips division and setup and gets a single response.
// Reset is synchronous and clears the queue and the back end control; no clearing pass runs.
// The two-entry queue accepts requests while the back end waits on rsp_ready, until it is full.
`default_nettype none

module integer_to_text_formatter_unit #(
   parameter int VALUE_BITS = ifmt_pkg::VALUE_BITS_DEF,
   parameter int MAX_WIDTH  = ifmt_pkg::MAX_WIDTH_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  ifmt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output ifmt_pkg::rsp_type rsp_data
);
   import ifmt_pkg::*;

   job_type front_job;
   job_type queue_job;
   logic    front_push;
   logic    queue_ready;
   logic    queue_valid;
   logic    back_pop;

   ifmt_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_push  (front_push),
      .job_ready (queue_ready),
      .job_data  (front_job)
   );

   ifmt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_ready (queue_ready),
      .push_data  (front_job),
      .pop_valid  (queue_valid),
      .pop        (back_pop),
      .pop_data   (queue_job)
   );

   ifmt_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job_pop   (back_pop),
      .job_data  (queue_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
